>>> rtl/vps_pkg.sv
// Package: shared types, register map and fixed-point constants of the vignette scaler.
`timescale 1ns / 1ps

package vps_pkg;

	// Field widths
	localparam int COORD_W  = 12;
	localparam int CHAN_W   = 8;
	localparam int DIM_W    = 13;
	localparam int SCALE_W  = 25;
	localparam int GAIN_W   = 17;

	// Distance datapath widths, fixed by the coordinate width
	localparam int D2_W     = 2 * COORD_W + 1;
	localparam int RAD_W    = D2_W + 9;
	localparam int ROOT_W   = RAD_W / 2;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SCALE_W;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SCALE  = 2'd2;

	localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 13'd480;
	localparam logic [SCALE_W-1:0] ANGLE_SCALE_RST  = 25'd65885;

	// Parameter defaults
	localparam int MAX_DIMENSION_DEF    = 4096;
	localparam int GAIN_TABLE_DEPTH_DEF = 1024;

	// pi/2 in Q28 and Q30, 1.0 in Q30
	localparam int                HALF_PI_Q28_W = 29;
	localparam longint unsigned   HALF_PI_Q28   = 64'd421657428;
	localparam longint unsigned   HALF_PI_Q30   = 64'd1686629713;
	localparam longint            ONE_Q30       = 64'sd1073741824;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [CHAN_W-1:0]  blue_in;
		logic [CHAN_W-1:0]  green_in;
		logic [CHAN_W-1:0]  red_in;
	} pix_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] red_out;
	} pix_out_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} bgr_t;

	localparam int BGR_W = $bits(bgr_t);

endpackage

>>> rtl/vps_stream_if.sv
// Interface: valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps

interface vps_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/vps_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module vps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> rtl/vps_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side-band payload.
`timescale 1ns / 1ps

module vps_sqrt #(
	parameter int RAD_W  = 34,
	parameter int SIDE_W = 24,
	localparam int RW = RAD_W / 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [RW-1:0]     out_root,
	output logic [SIDE_W-1:0] out_side
);

	logic              v_s    [RW];
	logic [RAD_W-1:0]  rad_s  [RW];
	logic [RW+1:0]     rem_s  [RW];
	logic [RW-1:0]     root_s [RW];
	logic [SIDE_W-1:0] side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic              v_prev;
		logic [RAD_W-1:0]  rad_prev;
		logic [RW+1:0]     rem_prev;
		logic [RW-1:0]     root_prev;
		logic [SIDE_W-1:0] side_prev;
		logic [RW+1:0]     rem_sh;
		logic [RW+1:0]     trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_prev    = in_valid;
			assign rad_prev  = in_rad;
			assign rem_prev  = '0;
			assign root_prev = '0;
			assign side_prev = in_side;
		end else begin : g_next
			assign v_prev    = v_s[k-1];
			assign rad_prev  = rad_s[k-1];
			assign rem_prev  = rem_s[k-1];
			assign root_prev = root_s[k-1];
			assign side_prev = side_s[k-1];
		end

		// bring down the next two radicand bits, try (2*root)*2+1
		assign rem_sh = {rem_prev[RW-1:0], rad_prev[RAD_W-1 -: 2]};
		assign trial  = {root_prev, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_prev << 2;
				rem_s[k]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[k] <= {root_prev[RW-2:0], ge};
				side_s[k] <= side_prev;
			end
		end
	end

	assign out_valid = v_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_side  = side_s[RW-1];

endmodule

>>> rtl/vps_index.sv
// Angle and table index: clamps the root, scales it to an angle, divides by pi/2 over stages.
`timescale 1ns / 1ps

module vps_index #(
	parameter int ROOT_W        = 17,
	parameter int MAX_DIMENSION = 4096,
	parameter int DEPTH         = 1024,
	parameter int SIDE_W        = 24,
	localparam int IW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [vps_pkg::SCALE_W-1:0] angle_scale,
	input  logic                       in_valid,
	input  logic [ROOT_W-1:0]          in_root,
	input  logic [SIDE_W-1:0]          in_side,
	output logic                       out_valid,
	output logic [IW-1:0]              out_idx,
	output logic [SIDE_W-1:0]          out_side
);

	localparam int RTW = $clog2(MAX_DIMENSION * 16);
	localparam int CW  = (ROOT_W > RTW) ? ROOT_W : RTW;
	localparam int TW  = RTW + vps_pkg::SCALE_W;
	localparam int HW  = vps_pkg::HALF_PI_Q28_W;
	localparam int NW  = IW + HW;

	localparam logic [CW-1:0] ROOT_MAX = CW'(MAX_DIMENSION * 16 - 1);
	localparam logic [TW-1:0] HALF_PI_T = TW'(vps_pkg::HALF_PI_Q28);
	localparam logic [NW-1:0] HALF_PI_N = NW'(vps_pkg::HALF_PI_Q28);
	localparam logic [NW-1:0] QUART_PI_N = NW'(vps_pkg::HALF_PI_Q28 / 2);
	localparam logic [NW-1:0] DEPTH_M1_N = NW'(DEPTH - 1);
	localparam logic [IW-1:0] IDX_LAST   = IW'(DEPTH - 1);

	logic [CW-1:0]  root_ext;
	logic [RTW-1:0] root_sat;

	logic              v_s1;
	logic [TW-1:0]     theta_s1;
	logic [SIDE_W-1:0] side_s1;

	logic              v_s2;
	logic              sat_s2;
	logic [NW-1:0]     n_s2;
	logic [SIDE_W-1:0] side_s2;

	logic              dv_s    [IW];
	logic              dsat_s  [IW];
	logic [NW-1:0]     dn_s    [IW];
	logic [IW-1:0]     dq_s    [IW];
	logic [SIDE_W-1:0] dside_s [IW];

	assign root_ext = CW'(in_root);
	assign root_sat = (root_ext > ROOT_MAX) ? RTW'(ROOT_MAX) : RTW'(root_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			theta_s1 <= TW'(root_sat) * TW'(angle_scale);
			side_s1  <= in_side;
			// past pi/2 the index pins to the last entry
			sat_s2   <= (theta_s1 >= HALF_PI_T);
			n_s2     <= NW'(theta_s1[HW-1:0]) * DEPTH_M1_N + QUART_PI_N;
			side_s2  <= side_s1;
		end
	end

	// restoring division by pi/2, one quotient bit per stage, MSB first
	for (genvar k = 0; k < IW; k++) begin : g_div
		localparam logic [NW-1:0] DIV_K = HALF_PI_N << (IW - 1 - k);

		logic              v_prev;
		logic              sat_prev;
		logic [NW-1:0]     n_prev;
		logic [IW-1:0]     q_prev;
		logic [SIDE_W-1:0] side_prev;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_prev    = v_s2;
			assign sat_prev  = sat_s2;
			assign n_prev    = n_s2;
			assign q_prev    = '0;
			assign side_prev = side_s2;
		end else begin : g_next
			assign v_prev    = dv_s[k-1];
			assign sat_prev  = dsat_s[k-1];
			assign n_prev    = dn_s[k-1];
			assign q_prev    = dq_s[k-1];
			assign side_prev = dside_s[k-1];
		end

		assign ge = (n_prev >= DIV_K);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (en) begin
				dv_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dsat_s[k]  <= sat_prev;
				dn_s[k]    <= ge ? (n_prev - DIV_K) : n_prev;
				dq_s[k]    <= {q_prev[IW-2:0], ge};
				dside_s[k] <= side_prev;
			end
		end
	end

	assign out_valid = dv_s[IW-1];
	assign out_idx   = dsat_s[IW-1] ? IDX_LAST : dq_s[IW-1];
	assign out_side  = dside_s[IW-1];

endmodule

>>> rtl/vps_gain.sv
// Gain table (RAM loaded after reset) and per-channel scaling.
`timescale 1ns / 1ps

module vps_gain #(
	parameter int DEPTH = 1024,
	localparam int IW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [IW-1:0] in_idx,
	input  vps_pkg::bgr_t in_bgr,
	output logic          fill_done,
	output logic          out_valid,
	output vps_pkg::bgr_t out_bgr
);

	localparam int GW = vps_pkg::GAIN_W;
	localparam int CH = vps_pkg::CHAN_W;
	localparam int PW = CH + GW;
	localparam longint unsigned DEPTH_M1 = 64'(DEPTH - 1);
	localparam longint HORNER_DEN [5] = '{
		vps_pkg::ONE_Q30 * 90, vps_pkg::ONE_Q30 * 56, vps_pkg::ONE_Q30 * 30,
		vps_pkg::ONE_Q30 * 12, vps_pkg::ONE_Q30 * 2
	};

	typedef logic [GW-1:0] gain_arr_t [DEPTH];

	// cos^2 over 0..pi/2: degree-10 Taylor cosine in Q30, squared to Q1.16
	function automatic logic [GW-1:0] gain_entry(input longint unsigned i);
		longint unsigned t;
		longint unsigned hu;
		longint          u;
		longint          h;
		t = (i * vps_pkg::HALF_PI_Q30 + DEPTH_M1 / 2) / DEPTH_M1;
		u = longint'((t * t) >> 30);
		h = vps_pkg::ONE_Q30;
		for (int k = 0; k < 5; k++) begin
			h = vps_pkg::ONE_Q30 - (u * h) / HORNER_DEN[k];
		end
		if (h < 0) begin
			h = 0;
		end
		if (h > vps_pkg::ONE_Q30) begin
			h = vps_pkg::ONE_Q30;
		end
		hu = longint'(h);
		return GW'((hu * hu) >> 44);
	endfunction

	function automatic gain_arr_t build_gain_table();
		gain_arr_t tbl;
		for (int i = 0; i < DEPTH; i++) begin
			tbl[i] = gain_entry(64'(i));
		end
		return tbl;
	endfunction

	localparam gain_arr_t GAIN_TABLE = build_gain_table();
	localparam logic [IW-1:0] FILL_LAST = IW'(DEPTH - 1);

	logic [IW-1:0] fill_q;
	logic          done_q;
	logic [GW-1:0] gain_rd;

	logic          v_s1;
	vps_pkg::bgr_t bgr_s1;
	logic          v_s2;
	vps_pkg::bgr_t bgr_s2;

	logic [PW-1:0] prod_b;
	logic [PW-1:0] prod_g;
	logic [PW-1:0] prod_r;

	// load sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else if (!done_q) begin
			if (fill_q == FILL_LAST) begin
				done_q <= 1'b1;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	vps_ram #(
		.WIDTH (GW),
		.DEPTH (DEPTH)
	) u_gain_ram (
		.clk     (clk),
		.wr_en   (!done_q),
		.wr_addr (fill_q),
		.wr_data (GAIN_TABLE[fill_q]),
		.rd_en   (en),
		.rd_addr (in_idx),
		.rd_data (gain_rd)
	);

	assign prod_b = PW'(bgr_s1.blue)  * PW'(gain_rd);
	assign prod_g = PW'(bgr_s1.green) * PW'(gain_rd);
	assign prod_r = PW'(bgr_s1.red)   * PW'(gain_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bgr_s1       <= in_bgr;
			bgr_s2.blue  <= prod_b[16 +: CH];
			bgr_s2.green <= prod_g[16 +: CH];
			bgr_s2.red   <= prod_r[16 +: CH];
		end
	end

	assign fill_done = done_q;
	assign out_valid = v_s2;
	assign out_bgr   = bgr_s2;

endmodule

>>> rtl/vignette_pixel_scaler_core.sv
// Top level: radial cos^2 vignette applied to a stream of BGR pixels.
//
//  port       | dir  | payload                                  | handshake
//  -----------+------+------------------------------------------+-------------------
//  pix_in     | sink | pixel_x, pixel_y, blue/green/red_in      | valid/ready
//  pix_out    | src  | blue_out, green_out, red_out             | valid/ready
//  cfg_*      | in   | cfg_idx, cfg_wdata (25 b)                | cfg_we, no wait
//
// One pixel per cycle while the pipeline is not stalled and the gain table is loaded.
// The stages in order: 3 front stages, one root bit per stage, the angle multiply,
// one index bit per stage of the division by pi/2, the table read and the scaling.
// After reset the gain RAM is loaded entry by entry; pix_in.ready stays low until it is done.
// A two-entry output buffer decouples the pipeline: it stalls only once both entries hold.
`timescale 1ns / 1ps

module vignette_pixel_scaler_core #(
	parameter int MAX_DIMENSION    = vps_pkg::MAX_DIMENSION_DEF,
	parameter int GAIN_TABLE_DEPTH = vps_pkg::GAIN_TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [vps_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [vps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	vps_stream_if.sink                     pix_in,
	vps_stream_if.source                   pix_out
);

	localparam int CW     = vps_pkg::COORD_W;
	localparam int DW     = vps_pkg::DIM_W;
	localparam int SW     = vps_pkg::SCALE_W;
	localparam int SQ_W   = 2 * CW;
	localparam int D2_W   = vps_pkg::D2_W;
	localparam int RAD_W  = vps_pkg::RAD_W;
	localparam int ROOT_W = vps_pkg::ROOT_W;
	localparam int BGR_W  = vps_pkg::BGR_W;
	localparam int IW     = $clog2(GAIN_TABLE_DEPTH);

	logic [DW-1:0] width_q;
	logic [DW-1:0] height_q;
	logic [SW-1:0] scale_q;

	logic en;
	logic in_acc;

	logic [CW-1:0] cx;
	logic [CW-1:0] cy;
	logic [CW-1:0] dx;
	logic [CW-1:0] dy;
	vps_pkg::bgr_t in_bgr;

	logic          v_s1;
	logic [CW-1:0] dx_s1;
	logic [CW-1:0] dy_s1;
	vps_pkg::bgr_t bgr_s1;

	logic            v_s2;
	logic [SQ_W-1:0] sqx_s2;
	logic [SQ_W-1:0] sqy_s2;
	vps_pkg::bgr_t   bgr_s2;

	logic            v_s3;
	logic [D2_W-1:0] d2_s3;
	vps_pkg::bgr_t   bgr_s3;

	logic              rt_valid;
	logic [ROOT_W-1:0] rt_root;
	logic [BGR_W-1:0]  rt_side;

	logic             ix_valid;
	logic [IW-1:0]    ix_idx;
	logic [BGR_W-1:0] ix_side;

	logic          fill_done;
	logic          gn_valid;
	vps_pkg::bgr_t gn_bgr;
	vps_pkg::pix_out_t gn_pix;

	logic              out_v_q;
	vps_pkg::pix_out_t out_d_q;
	logic              spare_v_q;
	vps_pkg::pix_out_t spare_d_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= vps_pkg::IMAGE_WIDTH_RST;
			height_q <= vps_pkg::IMAGE_HEIGHT_RST;
			scale_q  <= vps_pkg::ANGLE_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				vps_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata[DW-1:0];
				vps_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata[DW-1:0];
				vps_pkg::REG_ANGLE_SCALE:  scale_q  <= cfg_wdata[SW-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves while the spare output entry is free
	assign en           = !spare_v_q;
	assign pix_in.ready = en && fill_done;
	assign in_acc       = pix_in.valid && pix_in.ready;

	assign cx = width_q[DW-1:1];
	assign cy = height_q[DW-1:1];
	assign dx = (pix_in.data.pixel_x >= cx) ? (pix_in.data.pixel_x - cx)
	                                        : (cx - pix_in.data.pixel_x);
	assign dy = (pix_in.data.pixel_y >= cy) ? (pix_in.data.pixel_y - cy)
	                                        : (cy - pix_in.data.pixel_y);

	assign in_bgr.blue  = pix_in.data.blue_in;
	assign in_bgr.green = pix_in.data.green_in;
	assign in_bgr.red   = pix_in.data.red_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= dx;
			dy_s1  <= dy;
			bgr_s1 <= in_bgr;
			sqx_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
			sqy_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
			bgr_s2 <= bgr_s1;
			d2_s3  <= D2_W'(sqx_s2) + D2_W'(sqy_s2);
			bgr_s3 <= bgr_s2;
		end
	end

	// Q13.4 distance: sqrt(d2 * 256)
	vps_sqrt #(
		.RAD_W  (RAD_W),
		.SIDE_W (BGR_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_rad    (RAD_W'({d2_s3, 8'h00})),
		.in_side   (bgr_s3),
		.out_valid (rt_valid),
		.out_root  (rt_root),
		.out_side  (rt_side)
	);

	vps_index #(
		.ROOT_W        (ROOT_W),
		.MAX_DIMENSION (MAX_DIMENSION),
		.DEPTH         (GAIN_TABLE_DEPTH),
		.SIDE_W        (BGR_W)
	) u_index (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.angle_scale (scale_q),
		.in_valid    (rt_valid),
		.in_root     (rt_root),
		.in_side     (rt_side),
		.out_valid   (ix_valid),
		.out_idx     (ix_idx),
		.out_side    (ix_side)
	);

	vps_gain #(
		.DEPTH (GAIN_TABLE_DEPTH)
	) u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ix_valid),
		.in_idx    (ix_idx),
		.in_bgr    (vps_pkg::bgr_t'(ix_side)),
		.fill_done (fill_done),
		.out_valid (gn_valid),
		.out_bgr   (gn_bgr)
	);

	assign gn_pix.blue_out  = gn_bgr.blue;
	assign gn_pix.green_out = gn_bgr.green;
	assign gn_pix.red_out   = gn_bgr.red;

	// output register plus spare entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (out_v_q && !pix_out.ready) begin
			if (en && gn_valid) begin
				spare_v_q <= 1'b1;
			end
		end else if (spare_v_q) begin
			out_v_q   <= 1'b1;
			spare_v_q <= 1'b0;
		end else begin
			out_v_q <= en && gn_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !pix_out.ready) begin
			if (en && gn_valid) begin
				spare_d_q <= gn_pix;
			end
		end else if (spare_v_q) begin
			out_d_q <= spare_d_q;
		end else if (en && gn_valid) begin
			out_d_q <= gn_pix;
		end
	end

	assign pix_out.valid = out_v_q;
	assign pix_out.data  = out_d_q;

endmodule

>>> rtl/vps_checker.sv
// Port-level checker for the vignette scaler, bound to the top level.
`timescale 1ns / 1ps

module vps_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input vps_pkg::pix_out_t out_data
);

	logic        in_acc;
	logic        out_acc;
	logic [15:0] flight_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q <= '0;
		end else if (in_acc && !out_acc) begin
			flight_q <= flight_q + 1'b1;
		end else if (!in_acc && out_acc) begin
			flight_q <= flight_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output transaction changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> flight_q != 16'd0)
		else $error("output transaction without a pending input");

	// reset seen at the previous edge: table load still ahead
	a_load_after_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !in_ready)
		else $error("input ready before gain table load");

endmodule

bind vignette_pixel_scaler_core vps_checker u_vps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_data  (pix_out.data)
);

>>> dv/vignette_pixel_scaler_core_tb.sv
// Testbench: vignette scaler pixels checked against a fixed-point cos^2 predictor.
`timescale 1ns / 1ps

module vignette_pixel_scaler_core_tb;
	import vps_pkg::*;

	localparam int TABLE_DEPTH = GAIN_TABLE_DEPTH_DEF;
	localparam longint unsigned ROOT_SAT = MAX_DIMENSION_DEF * 16 - 1;
	localparam longint unsigned HALF_PI_Q24 = 64'd26353589;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int IDLE_PCT = 22;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 192;

	typedef struct packed {
		logic                  is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		pix_in_t               pix;
		logic                  known;
		pix_out_t              want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	vps_stream_if #(.T(pix_in_t))  pix_in_ch ();
	vps_stream_if #(.T(pix_out_t)) pix_out_ch ();

	vignette_pixel_scaler_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_in_ch),
		.pix_out   (pix_out_ch)
	);

	// predictor state: register copies and the gain table
	logic [DIM_W-1:0]   img_w;
	logic [DIM_W-1:0]   img_h;
	logic [SCALE_W-1:0] ang_scale;
	logic [GAIN_W-1:0]  gain_lut [TABLE_DEPTH];

	pix_out_t pending_pixels [$];
	dir_row_t directed_rows [$];
	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned pixels_sent = 0;
	int unsigned reg_writes = 0;
	bit steady = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#200000;
		$display("Timeout: %0d results still outstanding", pending_pixels.size());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe >>= 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v -= res + probe;
				res = (res >> 1) + probe;
			end else begin
				res >>= 1;
			end
			probe >>= 2;
		end
		return res;
	endfunction

	// Q30 Taylor cosine (degree 10), squared down to Q1.16
	function automatic logic [GAIN_W-1:0] cos_sq_gain(int unsigned i);
		longint unsigned t;
		longint u;
		longint h;
		longint step_div [5];
		step_div = '{90, 56, 30, 12, 2};
		t = (64'(i) * HALF_PI_Q30 + (TABLE_DEPTH - 1) / 2) / (TABLE_DEPTH - 1);
		u = longint'((t * t) >> 30);
		h = ONE_Q30;
		for (int k = 0; k < 5; k++)
			h = ONE_Q30 - (u * h) / (ONE_Q30 * step_div[k]);
		if (h < 0)
			h = 0;
		if (h > ONE_Q30)
			h = ONE_Q30;
		return GAIN_W'((h * h) >> 44);
	endfunction

	function automatic pix_out_t vignette_result(pix_in_t p);
		longint unsigned cx, cy, dx, dy, root, theta, idx, g;
		pix_out_t r;
		cx = img_w >> 1;
		cy = img_h >> 1;
		dx = (p.pixel_x >= cx) ? p.pixel_x - cx : cx - p.pixel_x;
		dy = (p.pixel_y >= cy) ? p.pixel_y - cy : cy - p.pixel_y;
		root = int_sqrt((dx * dx + dy * dy) << 8);
		if (root > ROOT_SAT)
			root = ROOT_SAT;
		theta = root * ang_scale;
		idx = (theta * (TABLE_DEPTH - 1) + HALF_PI_Q28 / 2) / HALF_PI_Q28;
		if (idx > TABLE_DEPTH - 1)
			idx = TABLE_DEPTH - 1;
		g = gain_lut[idx];
		r.blue_out  = CHAN_W'((p.blue_in * g) >> 16);
		r.green_out = CHAN_W'((p.green_in * g) >> 16);
		r.red_out   = CHAN_W'((p.red_in * g) >> 16);
		return r;
	endfunction

	// angle scale software would load: (pi/2) / distance to the (0,0) corner
	function automatic logic [SCALE_W-1:0] matched_scale(logic [DIM_W-1:0] w,
			logic [DIM_W-1:0] h);
		longint unsigned cx, cy, r16, s;
		cx = w >> 1;
		cy = h >> 1;
		r16 = int_sqrt((cx * cx + cy * cy) << 8);
		if (r16 == 0)
			return '1;
		s = (HALF_PI_Q24 * 16) / r16;
		if (s > 64'h1FFFFFF)
			s = 64'h1FFFFFF;
		if (s == 0)
			s = 1;
		return SCALE_W'(s);
	endfunction

	function automatic logic [DIM_W-1:0] pick_dimension();
		case ($urandom_range(5))
			0: return 13'd1;
			1: return 13'd4096;
			2: return 13'd640;
			3: return 13'd1080;
			default: return DIM_W'($urandom_range(4096, 1));
		endcase
	endfunction

	function automatic dir_row_t pix_row(int x, int y, int b, int g, int r);
		dir_row_t row;
		row = '0;
		row.pix = '{COORD_W'(x), COORD_W'(y), CHAN_W'(b), CHAN_W'(g), CHAN_W'(r)};
		return row;
	endfunction

	function automatic dir_row_t pix_known(int x, int y, int b, int g, int r,
			int eb, int eg, int er);
		dir_row_t row;
		row = pix_row(x, y, b, g, r);
		row.known = 1'b1;
		row.want = '{CHAN_W'(eb), CHAN_W'(eg), CHAN_W'(er)};
		return row;
	endfunction

	function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		dir_row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_channel(string name, logic [CHAN_W-1:0] got,
			logic [CHAN_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_IMAGE_WIDTH:  img_w = val[DIM_W-1:0];
			REG_IMAGE_HEIGHT: img_h = val[DIM_W-1:0];
			REG_ANGLE_SCALE:  ang_scale = val[SCALE_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// called and returns at a falling edge
	task automatic send_pixel(pix_in_t p, bit known, pix_out_t want);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			pix_in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in_ch.valid <= 1'b1;
		pix_in_ch.data <= p;
		@(posedge clk);
		while (!pix_in_ch.ready)
			@(posedge clk);
		pending_pixels.push_back(known ? want : vignette_result(p));
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		pix_in_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	always @(negedge clk)
		if (arst_n)
			pix_out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin : check_results
		pix_out_t want;
		if (arst_n && pix_out_ch.valid && pix_out_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("result transaction with nothing pending");
			end else begin
				want = pending_pixels.pop_front();
				check_channel("blue_out", pix_out_ch.data.blue_out, want.blue_out);
				check_channel("green_out", pix_out_ch.data.green_out, want.green_out);
				check_channel("red_out", pix_out_ch.data.red_out, want.red_out);
			end
			results_checked++;
		end
	end

	initial begin
		pix_in_t p;
		pix_out_t none;
		logic [DIM_W-1:0] w, h;
		int unsigned x_lim, y_lim, directed_pixels;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_IMAGE_WIDTH;
		cfg_wdata = '0;
		pix_in_ch.valid = 1'b0;
		pix_in_ch.data = '0;
		pix_out_ch.ready = 1'b0;
		none = '0;
		img_w = IMAGE_WIDTH_RST;
		img_h = IMAGE_HEIGHT_RST;
		ang_scale = ANGLE_SCALE_RST;
		for (int i = 0; i < TABLE_DEPTH; i++)
			gain_lut[i] = cos_sq_gain(i);

		directed_rows = '{
			pix_known(320, 240, 255, 255, 255, 255, 255, 255),
			pix_known(320, 240, 0, 0, 0, 0, 0, 0),
			pix_known(320, 240, 'hAA, 'h55, 'h01, 'hAA, 'h55, 'h01),
			pix_row(0, 0, 255, 255, 255),
			pix_row(639, 479, 'h80, 'h7F, 'hFF),
			pix_known(4095, 4095, 255, 255, 255, 0, 0, 0),
			pix_row(4095, 0, 'hC3, 'h3C, 'h99),
			pix_row(0, 4095, 'h5A, 'hA5, 'hFF),
			pix_row(330, 245, 200, 100, 50),
			pix_row('hAAA, 'h555, 'h55, 'hAA, 'h0F),
			pix_row('h555, 'hAAA, 'hAA, 'h55, 'hF0),
			reg_row(REG_ANGLE_SCALE, 25'd0),
			pix_known(4095, 4095, 255, 128, 1, 255, 128, 1),
			reg_row(REG_ANGLE_SCALE, 25'h1FFFFFF),
			pix_row(321, 240, 255, 255, 255),
			pix_known(320, 240, 9, 8, 7, 9, 8, 7),
			reg_row(REG_IMAGE_WIDTH, 25'd0),
			reg_row(REG_IMAGE_HEIGHT, 25'd0),
			reg_row(REG_ANGLE_SCALE, 25'd1),
			pix_known(0, 0, 255, 255, 255, 255, 255, 255),
			pix_row(4095, 4095, 255, 255, 255),
			reg_row(REG_IMAGE_WIDTH, 25'h1FFF),
			reg_row(REG_IMAGE_HEIGHT, 25'h1FFFFFF),
			reg_row(REG_UNMAPPED, 25'h1FFFFFF),
			pix_known(4095, 4095, 1, 2, 3, 1, 2, 3),
			pix_row(0, 0, 255, 255, 255),
			reg_row(REG_IMAGE_WIDTH, 25'd1),
			reg_row(REG_IMAGE_HEIGHT, 25'd4096),
			reg_row(REG_ANGLE_SCALE, 25'd65885),
			pix_row(0, 0, 17, 34, 68),
			pix_row(4095, 2048, 255, 254, 253)
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_reg) begin
				wait_drained();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				send_pixel(directed_rows[i].pix, directed_rows[i].known,
					directed_rows[i].want);
			end
		end
		directed_pixels = pixels_sent;

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			if (phase == 0) begin
				w = 13'd640;
				h = 13'd480;
			end else begin
				w = pick_dimension();
				h = pick_dimension();
			end
			write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
			write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
			case ($urandom_range(4))
				0: write_reg(REG_ANGLE_SCALE, CFG_DATA_W'($urandom_range(25'h1FFFFFF, 1)));
				1: write_reg(REG_ANGLE_SCALE, 25'h1FFFFFF);
				default: write_reg(REG_ANGLE_SCALE, matched_scale(w, h));
			endcase
			steady = (phase == 0);
			x_lim = (img_w > 4096) ? 4095 : img_w - 1;
			y_lim = (img_h > 4096) ? 4095 : img_h - 1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 3 && n == ITEMS_PER_PHASE / 2)
					wait_drained();
				if ($urandom_range(9) < 8) begin
					p.pixel_x = $urandom_range(x_lim);
					p.pixel_y = $urandom_range(y_lim);
				end else begin
					p.pixel_x = $urandom_range(4095);
					p.pixel_y = $urandom_range(4095);
				end
				p.blue_in = $urandom_range(255);
				p.green_in = $urandom_range(255);
				p.red_in = $urandom_range(255);
				send_pixel(p, 1'b0, none);
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (40) @(posedge clk);
		$display("Sent %0d pixels (%0d directed) over %0d register writes,", pixels_sent,
			directed_pixels, reg_writes);
		$display("zero, unmapped and full-scale settings included; %0d results, %0d bad.",
			results_checked, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
rtl/vps_pkg.sv
rtl/vps_stream_if.sv
rtl/vps_ram.sv
rtl/vps_sqrt.sv
rtl/vps_index.sv
rtl/vps_gain.sv
rtl/vignette_pixel_scaler_core.sv
rtl/vps_checker.sv
dv/vignette_pixel_scaler_core_tb.sv
